@@ hw/rtl/mnpa_pkg.sv @@
// Shared types, codes and constants of the monophonic note priority assigner.
// No dependencies; every other file but mnpa_stream_if imports this package.
package mnpa_pkg;

  localparam int unsigned NOTE_BUTTONS = 10;
  localparam int unsigned BTN_W        = 4;
  localparam int unsigned NOTE_W       = 7;
  localparam int unsigned SCALE_W      = 35;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 35;
  localparam int unsigned EVENT_DEPTH  = 4;

  localparam logic [BTN_W-1:0] SHIFT_OWNER = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROFILE  = 2'd0,
    CFG_SCALE_LO = 2'd1,
    CFG_SCALE_HI = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_OFF    = 2'd0,
    EV_PLAY   = 2'd1,
    EV_STOP   = 2'd2,
    EV_RETRIG = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    BEND_NONE = 2'd0,
    BEND_DOWN = 2'd1,
    BEND_UP   = 2'd2
  } bend_e;

  typedef struct packed {
    logic [NOTE_BUTTONS-1:0] pressed_mask;
    logic [NOTE_BUTTONS-1:0] released_mask;
    logic [NOTE_BUTTONS-1:0] held_mask;
    logic                    down_shift_held;
    logic                    up_shift_held;
    logic                    down_shift_pressed;
  } scan_t;

  typedef struct packed {
    event_kind_e       event_kind;
    logic [NOTE_W-1:0] note_number;
    logic              last_event;
  } event_t;

  typedef struct packed {
    logic               profile_select;
    logic [SCALE_W-1:0] scale_notes_low;
    logic [SCALE_W-1:0] scale_notes_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } ev_pair_t;

endpackage

@@ hw/rtl/mnpa_stream_if.sv @@
// Valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; used with types from mnpa_pkg.
interface mnpa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mono_note_priority_assigner_top.sv @@
// Top level of the monophonic note priority assigner.
// Depends on mnpa_pkg, mnpa_stream_if, mnpa_decide and mnpa_event_fifo.
//
// Usage:
//   scan_i carries one button scan per transfer; event_o carries one MIDI or
//   audio event per transfer, last_event marking the final event of a scan.
//   A scan causes zero, one or two events.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle; indexes: profile, scale notes low, scale notes high.
// Timing:
//   A scan is held in an input register, decided combinationally, and its
//   events are registered into a four-entry event buffer, from which they
//   are offered. One scan is taken per cycle while the buffer has room;
//   throughput is set by the single event output port, one event per cycle
//   while the receiver is ready, so each event of a scan takes its own transfer.
// Reset and stall:
//   Reset clears the voice state, the registers and the buffer. When the
//   receiver stalls, the buffer fills and scan_i.ready drops while a scan waits
//   in the input register and fewer than two entries are free; nothing is lost.
module mono_note_priority_assigner_top #(
  parameter int unsigned EventDepth = mnpa_pkg::EVENT_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mnpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mnpa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  mnpa_stream_if.sink                         scan_i,
  mnpa_stream_if.source                       event_o
);
  import mnpa_pkg::*;

  cfg_t     cfg_q;
  scan_t    scan_q;
  logic     scan_vld_q;
  logic     room;
  logic     advance;
  ev_pair_t evs;
  ev_pair_t push;

  assign advance      = scan_vld_q && room;
  assign scan_i.ready = !scan_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PROFILE:  cfg_q.profile_select   <= cfg_wdata_i[0];
        CFG_SCALE_LO: cfg_q.scale_notes_low  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SCALE_HI: cfg_q.scale_notes_high <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else if (scan_i.ready) begin
      scan_vld_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.valid && scan_i.ready) begin
      scan_q <= scan_i.payload;
    end
  end

  mnpa_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .scan_i    (scan_q),
    .advance_i (advance),
    .evs_o     (evs)
  );

  always_comb begin
    push = evs;
    if (!advance) push.count = 2'd0;
  end

  mnpa_event_fifo #(
    .Depth (EventDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (event_o.valid),
    .ready_i (event_o.ready),
    .event_o (event_o.payload)
  );

endmodule

@@ hw/rtl/mnpa_decide.sv @@
// Note priority decision: voice state registers and the per-scan event logic.
// Depends on mnpa_pkg.
module mnpa_decide (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mnpa_pkg::cfg_t   cfg_i,
  input  mnpa_pkg::scan_t  scan_i,
  input  logic             advance_i,
  output mnpa_pkg::ev_pair_t evs_o
);
  import mnpa_pkg::*;

  logic [NOTE_W-1:0] sounding_note_q, sounding_note_d;
  logic              note_active_q, note_active_d;
  logic [BTN_W-1:0]  owner_button_q, owner_button_d;
  logic              owner_valid_q, owner_valid_d;
  bend_e             last_bend_q, last_bend_d;

  function automatic logic [3:0] pos_of(input logic [BTN_W-1:0] btn);
    logic [3:0] p;
    case (btn)
      4'd0:    p = 4'd7;
      4'd1:    p = 4'd6;
      4'd2:    p = 4'd4;
      4'd3:    p = 4'd5;
      4'd4:    p = 4'd2;
      4'd5:    p = 4'd0;
      4'd6:    p = 4'd1;
      4'd7:    p = 4'd3;
      4'd8:    p = 4'd9;
      4'd9:    p = 4'd8;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

  function automatic logic [NOTE_W-1:0] riff_of(input logic [BTN_W-1:0] btn);
    logic [NOTE_W-1:0] n;
    case (btn)
      4'd0:    n = 7'd79;
      4'd1:    n = 7'd78;
      4'd2:    n = 7'd75;
      4'd3:    n = 7'd76;
      4'd8:    n = 7'd81;
      4'd9:    n = 7'd80;
      default: n = 7'd71;
    endcase
    return n;
  endfunction

  function automatic logic [NOTE_W-1:0] sat_note(input logic [NOTE_W-1:0] base,
                                                 input bend_e bend);
    logic [NOTE_W:0]   sum;
    logic [NOTE_W-1:0] res;
    sum = {1'b0, base} + 8'd12;
    case (bend)
      BEND_UP:   res = sum[NOTE_W] ? 7'd127 : sum[NOTE_W-1:0];
      BEND_DOWN: res = (base < 7'd12) ? 7'd0 : base - 7'd12;
      default:   res = base;
    endcase
    return res;
  endfunction

  logic [NOTE_W-1:0] scale_note [NOTE_BUTTONS];
  logic [2*SCALE_W-1:0] scale_all;

  assign scale_all = {cfg_i.scale_notes_high, cfg_i.scale_notes_low};

  always_comb begin
    for (int k = 0; k < NOTE_BUTTONS; k++) begin
      scale_note[k] = scale_all[NOTE_W*k +: NOTE_W];
    end
  end

  // base note of a button code; valid flag clear when there is none
  function automatic logic [NOTE_W:0] base_of(input logic [BTN_W-1:0] btn,
                                              input logic riff,
                                              input logic [NOTE_W-1:0] tbl [NOTE_BUTTONS]);
    logic [NOTE_W:0] r;
    logic [3:0]      p;
    p = pos_of(btn);
    if (riff) begin
      r = {(btn <= SHIFT_OWNER), riff_of(btn)};
    end else if (btn < SHIFT_OWNER) begin
      r = {1'b1, tbl[p]};
    end else begin
      r = '0;
    end
    return r;
  endfunction

  always_comb begin
    logic            riff;
    bend_e           bend;
    logic            have_new;
    logic [BTN_W-1:0] new_btn;
    logic [15:0]     rel_pad;
    logic            found;
    logic [BTN_W-1:0] next_btn;
    logic [NOTE_W:0] b;
    logic [NOTE_W-1:0] fin;
    event_t          e0, e1;
    logic [1:0]      n;

    riff     = cfg_i.profile_select;
    bend     = BEND_NONE;
    have_new = 1'b0;
    new_btn  = '0;
    found    = 1'b0;
    next_btn = '0;
    b        = '0;
    fin      = '0;
    e0       = '0;
    e1       = '0;
    n        = 2'd0;
    rel_pad  = {{(16-NOTE_BUTTONS){1'b0}}, scan_i.released_mask};

    sounding_note_d = sounding_note_q;
    note_active_d   = note_active_q;
    owner_button_d  = owner_button_q;
    owner_valid_d   = owner_valid_q;

    if (riff) begin
      if (scan_i.up_shift_held) bend = BEND_UP;
    end else if (scan_i.down_shift_held && !scan_i.up_shift_held) begin
      bend = BEND_DOWN;
    end else if (scan_i.up_shift_held && !scan_i.down_shift_held) begin
      bend = BEND_UP;
    end

    for (int i = 0; i < NOTE_BUTTONS; i++) begin
      if (scan_i.pressed_mask[i]) begin
        have_new = 1'b1;
        new_btn  = BTN_W'(i);
      end
    end
    if (!have_new && riff && scan_i.down_shift_pressed) begin
      have_new = 1'b1;
      new_btn  = SHIFT_OWNER;
    end

    for (int i = NOTE_BUTTONS - 1; i >= 0; i--) begin
      if (scan_i.held_mask[i] && (BTN_W'(i) != owner_button_q)) begin
        found    = 1'b1;
        next_btn = BTN_W'(i);
      end
    end

    if (have_new) begin
      b = base_of(new_btn, riff, scale_note);
      if (note_active_q && (!owner_valid_q || owner_button_q != new_btn)) begin
        e0 = '{EV_OFF, sounding_note_q, 1'b0};
        n  = 2'd1;
      end
      if (b[NOTE_W]) begin
        fin = sat_note(b[NOTE_W-1:0], bend);
        if (n == 2'd0) e0 = '{EV_PLAY, fin, 1'b0};
        else           e1 = '{EV_PLAY, fin, 1'b0};
        sounding_note_d = fin;
        note_active_d   = 1'b1;
        owner_button_d  = new_btn;
        owner_valid_d   = 1'b1;
      end else begin
        if (n == 2'd0) e0 = '{EV_STOP, 7'd0, 1'b0};
        else           e1 = '{EV_STOP, 7'd0, 1'b0};
        sounding_note_d = '0;
        note_active_d   = 1'b0;
        owner_button_d  = '0;
        owner_valid_d   = 1'b0;
      end
      n = n + 2'd1;
    end else if (owner_valid_q && owner_button_q < SHIFT_OWNER && rel_pad[owner_button_q]) begin
      if (note_active_q) begin
        e0 = '{EV_OFF, sounding_note_q, 1'b0};
        n  = 2'd1;
      end
      if (found) begin
        b   = base_of(next_btn, riff, scale_note);
        fin = sat_note(b[NOTE_W-1:0], bend);
        if (n == 2'd0) e0 = '{EV_PLAY, fin, 1'b0};
        else           e1 = '{EV_PLAY, fin, 1'b0};
        sounding_note_d = fin;
        note_active_d   = 1'b1;
        owner_button_d  = next_btn;
      end else begin
        if (n == 2'd0) e0 = '{EV_STOP, 7'd0, 1'b0};
        else           e1 = '{EV_STOP, 7'd0, 1'b0};
        sounding_note_d = '0;
        note_active_d   = 1'b0;
        owner_button_d  = '0;
        owner_valid_d   = 1'b0;
      end
      n = n + 2'd1;
    end else if (bend != last_bend_q && owner_valid_q) begin
      b = base_of(owner_button_q, riff, scale_note);
      if (b[NOTE_W]) begin
        fin = sat_note(b[NOTE_W-1:0], bend);
        if (note_active_q && sounding_note_q != fin) begin
          e0 = '{EV_OFF, sounding_note_q, 1'b0};
          e1 = '{EV_PLAY, fin, 1'b0};
          n  = 2'd2;
        end else begin
          e0 = '{(note_active_q ? EV_RETRIG : EV_PLAY), fin, 1'b0};
          n  = 2'd1;
        end
        sounding_note_d = fin;
        note_active_d   = 1'b1;
      end
    end

    last_bend_d = bend;

    if (n == 2'd2) e1.last_event = 1'b1;
    else           e0.last_event = 1'b1;

    evs_o = '{n, e0, e1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounding_note_q <= '0;
      note_active_q   <= 1'b0;
      owner_button_q  <= '0;
      owner_valid_q   <= 1'b0;
      last_bend_q     <= BEND_NONE;
    end else if (advance_i) begin
      sounding_note_q <= sounding_note_d;
      note_active_q   <= note_active_d;
      owner_button_q  <= owner_button_d;
      owner_valid_q   <= owner_valid_d;
      last_bend_q     <= last_bend_d;
    end
  end

endmodule

@@ hw/rtl/mnpa_event_fifo.sv @@
// Result buffer: takes up to two events per cycle, hands out one per transfer.
// Depends on mnpa_pkg. Depth must be a power of two, at least 2.
module mnpa_event_fifo #(
  parameter int unsigned Depth = mnpa_pkg::EVENT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mnpa_pkg::ev_pair_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output mnpa_pkg::event_t   event_o
);
  import mnpa_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  event_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign event_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.ev0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.ev1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/mnpa_checker.sv @@
// Port-level checks on the event channel of the note priority assigner.
// Depends on mnpa_pkg; bound to mono_note_priority_assigner_top below.
module mnpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         ev_valid_i,
  input logic                         ev_ready_i,
  input mnpa_pkg::event_t             ev_i
);
  import mnpa_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(ev_i))
  else $error("stalled event changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_i.event_kind == EV_STOP |-> ev_i.note_number == '0)
  else $error("audio stop with nonzero note");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_i.event_kind == EV_OFF |-> !ev_i.last_event)
  else $error("note off ended a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_i.event_kind == EV_RETRIG |-> ev_i.last_event)
  else $error("retrigger not alone");

endmodule

bind mono_note_priority_assigner_top mnpa_checker u_mnpa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .ev_valid_i (event_o.valid),
  .ev_ready_i (event_o.ready),
  .ev_i       (event_o.payload)
);

@@ verif/tb_mono_note_priority_assigner_top.sv @@
`timescale 1ns / 100ps
// Testbench for mono_note_priority_assigner_top: directed and random button scans,
// every event checked in order against a voice model kept in the bench.
// Depends on mnpa_pkg, mnpa_stream_if and the RTL top level.
module tb_mono_note_priority_assigner_top;
  import mnpa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_SCANS    = 150;
  localparam int          RIFF_SHIFT_NOTE = 71;
  localparam int          OCTAVE          = 12;
  localparam int          NOTE_MAX        = 127;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mnpa_stream_if #(.payload_t(scan_t))  scan_ch ();
  mnpa_stream_if #(.payload_t(event_t)) event_ch ();

  mono_note_priority_assigner_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .scan_i  (scan_ch),
    .event_o (event_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic               cfg_profile  = 1'b0;
  logic [SCALE_W-1:0] cfg_scale_lo = '0;
  logic [SCALE_W-1:0] cfg_scale_hi = '0;

  logic [NOTE_W-1:0] voice_note   = '0;
  logic              voice_active = 1'b0;
  logic [BTN_W-1:0]  voice_owner  = '0;
  logic              voice_owned  = 1'b0;
  bend_e             prev_bend    = BEND_NONE;

  event_t expected_events[$];
  int     mismatch_count = 0;
  int     idle_cycles    = 0;
  bit     src_burst      = 1'b0;
  bit     sink_burst     = 1'b0;

  logic [NOTE_BUTTONS-1:0] phys_held = '0;
  logic                    phys_down = 1'b0;
  logic                    phys_up   = 1'b0;

  function automatic int scale_position(logic [BTN_W-1:0] btn);
    case (btn)
      4'd0: return 7;
      4'd1: return 6;
      4'd2: return 4;
      4'd3: return 5;
      4'd4: return 2;
      4'd5: return 0;
      4'd6: return 1;
      4'd7: return 3;
      4'd8: return 9;
      default: return 8;
    endcase
  endfunction

  function automatic int riff_note(logic [BTN_W-1:0] btn);
    case (btn)
      4'd0: return 79;
      4'd1: return 78;
      4'd2: return 75;
      4'd3: return 76;
      4'd8: return 81;
      4'd9: return 80;
      default: return 71;
    endcase
  endfunction

  function automatic int button_base(logic [BTN_W-1:0] btn);
    int pos;
    if (cfg_profile) begin
      if (btn == SHIFT_OWNER) return RIFF_SHIFT_NOTE;
      if (btn < NOTE_BUTTONS) return riff_note(btn);
      return -1;
    end
    if (btn >= NOTE_BUTTONS) return -1;
    pos = scale_position(btn);
    if (pos < 5) return int'(cfg_scale_lo[NOTE_W*pos +: NOTE_W]);
    return int'(cfg_scale_hi[NOTE_W*(pos-5) +: NOTE_W]);
  endfunction

  function automatic logic [NOTE_W-1:0] clamp_note(int v);
    if (v < 0) return '0;
    if (v > NOTE_MAX) return NOTE_W'(NOTE_MAX);
    return NOTE_W'(v);
  endfunction

  function automatic event_t make_event(event_kind_e kind, logic [NOTE_W-1:0] note);
    event_t ev;
    ev.event_kind  = kind;
    ev.note_number = note;
    ev.last_event  = 1'b0;
    return ev;
  endfunction

  function automatic void predict_scan_events(scan_t s);
    event_t            evs[$];
    int                bend_amt;
    bend_e             bend_code;
    logic              have_new;
    logic              found;
    logic [BTN_W-1:0]  new_btn;
    logic [BTN_W-1:0]  next_btn;
    int                base;
    logic [NOTE_W-1:0] fin;
    bend_amt  = 0;
    bend_code = BEND_NONE;
    have_new  = 1'b0;
    found     = 1'b0;
    new_btn   = '0;
    next_btn  = '0;
    if (cfg_profile) begin
      if (s.up_shift_held) begin
        bend_amt  = OCTAVE;
        bend_code = BEND_UP;
      end
    end else if (s.down_shift_held && !s.up_shift_held) begin
      bend_amt  = -OCTAVE;
      bend_code = BEND_DOWN;
    end else if (s.up_shift_held && !s.down_shift_held) begin
      bend_amt  = OCTAVE;
      bend_code = BEND_UP;
    end
    for (int i = 0; i < NOTE_BUTTONS; i++) begin
      if (s.pressed_mask[i]) begin
        have_new = 1'b1;
        new_btn  = BTN_W'(i);
      end
    end
    if (!have_new && cfg_profile && s.down_shift_pressed) begin
      have_new = 1'b1;
      new_btn  = SHIFT_OWNER;
    end
    if (have_new) begin
      base = button_base(new_btn);
      if (voice_active && (!voice_owned || voice_owner != new_btn))
        evs.push_back(make_event(EV_OFF, voice_note));
      if (base >= 0) begin
        voice_note = clamp_note(base + bend_amt);
        evs.push_back(make_event(EV_PLAY, voice_note));
        voice_active = 1'b1;
        voice_owner  = new_btn;
        voice_owned  = 1'b1;
      end else begin
        evs.push_back(make_event(EV_STOP, '0));
        voice_active = 1'b0;
        voice_owned  = 1'b0;
        voice_note   = '0;
        voice_owner  = '0;
      end
    end else if (voice_owned && voice_owner < NOTE_BUTTONS &&
                 s.released_mask[voice_owner]) begin
      for (int i = 0; i < NOTE_BUTTONS; i++) begin
        if (!found && i != voice_owner && s.held_mask[i]) begin
          found    = 1'b1;
          next_btn = BTN_W'(i);
        end
      end
      if (voice_active) evs.push_back(make_event(EV_OFF, voice_note));
      if (found) begin
        voice_note = clamp_note(button_base(next_btn) + bend_amt);
        evs.push_back(make_event(EV_PLAY, voice_note));
        voice_active = 1'b1;
        voice_owner  = next_btn;
      end else begin
        evs.push_back(make_event(EV_STOP, '0));
        voice_active = 1'b0;
        voice_owned  = 1'b0;
        voice_note   = '0;
        voice_owner  = '0;
      end
    end else if (bend_code != prev_bend && voice_owned) begin
      base = button_base(voice_owner);
      if (base >= 0) begin
        fin = clamp_note(base + bend_amt);
        if (voice_active && voice_note != fin) evs.push_back(make_event(EV_OFF, voice_note));
        evs.push_back(make_event((!voice_active || voice_note != fin) ? EV_PLAY : EV_RETRIG,
                                 fin));
        voice_note   = fin;
        voice_active = 1'b1;
      end
    end
    prev_bend = bend_code;
    if (evs.size() > 0) evs[evs.size()-1].last_event = 1'b1;
    foreach (evs[k]) expected_events.push_back(evs[k]);
  endfunction

  function automatic scan_t mk_scan(input logic [NOTE_BUTTONS-1:0] p, r, h,
                                    input logic dh, uh, dp);
    scan_t s;
    s.pressed_mask       = p;
    s.released_mask      = r;
    s.held_mask          = h;
    s.down_shift_held    = dh;
    s.up_shift_held      = uh;
    s.down_shift_pressed = dp;
    return s;
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    return SCALE_W'({$urandom, $urandom});
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_scan(scan_t s);
    int   gap;
    logic rdy;
    if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      scan_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    scan_ch.valid   <= 1'b1;
    scan_ch.payload <= s;
    do begin
      @(negedge clk_i);
      rdy = scan_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    predict_scan_events(s);
  endtask

  task automatic drain_events();
    scan_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(logic profile, logic [SCALE_W-1:0] lo, logic [SCALE_W-1:0] hi);
    logic [CFG_DATA_W-1:0] pdata;
    pdata    = CFG_DATA_W'({$urandom, $urandom});
    pdata[0] = profile;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PROFILE;
    cfg_wdata_i <= pdata;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SCALE_LO;
    cfg_wdata_i <= CFG_DATA_W'(lo);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SCALE_HI;
    cfg_wdata_i <= CFG_DATA_W'(hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_profile  = profile;
    cfg_scale_lo = lo;
    cfg_scale_hi = hi;
  endtask

  function automatic scan_t next_random_scan();
    logic [NOTE_BUTTONS-1:0] p;
    logic [NOTE_BUTTONS-1:0] r;
    logic                    dn;
    logic                    up;
    logic                    dp;
    int                      b;
    if ($urandom_range(0, 4) == 0)
      return mk_scan(NOTE_BUTTONS'($urandom), NOTE_BUTTONS'($urandom), NOTE_BUTTONS'($urandom),
                     1'($urandom), 1'($urandom), 1'($urandom));
    p = '0;
    r = phys_held & NOTE_BUTTONS'($urandom) & NOTE_BUTTONS'($urandom);
    case ($urandom_range(0, 3))
      0: p = '0;
      3: p = ~phys_held & NOTE_BUTTONS'($urandom);
      default: begin
        b = $urandom_range(0, NOTE_BUTTONS - 1);
        if (!phys_held[b]) p[b] = 1'b1;
      end
    endcase
    dn = ($urandom_range(0, 5) == 0) ? !phys_down : phys_down;
    up = ($urandom_range(0, 5) == 0) ? !phys_up : phys_up;
    dp = dn && !phys_down;
    phys_held = (phys_held & ~r) | p;
    phys_down = dn;
    phys_up   = up;
    return mk_scan(p, r, phys_held, dn, up, dp);
  endfunction

  task automatic test_reset_state();
    send_scan(mk_scan(10'b0000000001, '0, 10'b0000000001, 1'b1, 1'b0, 1'b0));
    send_scan(mk_scan(10'b1000001000, '0, 10'b1000001001, 1'b0, 1'b1, 1'b0));
    send_scan(mk_scan('0, 10'b1111111111, '0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_scale_profile();
    drain_events();
    load_config(1'b0, {7'd66, 7'd65, 7'd64, 7'd0, 7'd127},
                {7'd120, 7'd70, 7'd69, 7'd68, 7'd67});
    send_scan(mk_scan(10'b0000100000, '0, 10'b0000100000, 1'b0, 1'b1, 1'b0));
    send_scan(mk_scan(10'b0000100000, '0, 10'b0000100000, 1'b0, 1'b1, 1'b0));
    send_scan(mk_scan('0, '0, 10'b0000100000, 1'b0, 1'b0, 1'b0));
    send_scan(mk_scan('0, '0, 10'b0000100000, 1'b1, 1'b0, 1'b1));
    send_scan(mk_scan('0, '0, 10'b0000100000, 1'b1, 1'b1, 1'b0));
    send_scan(mk_scan(10'b0010000100, '0, 10'b0010100100, 1'b0, 1'b0, 1'b0));
    send_scan(mk_scan('0, 10'b0000000100, 10'b0010100000, 1'b0, 1'b0, 1'b0));
    send_scan(mk_scan('0, 10'b0010000000, 10'b0000100000, 1'b0, 1'b0, 1'b0));
    send_scan(mk_scan('0, 10'b0000100000, '0, 1'b0, 1'b0, 1'b0));
    send_scan(mk_scan('0, '0, '0, 1'b0, 1'b1, 1'b0));
    send_scan(mk_scan(10'b0001000000, '0, 10'b0001000000, 1'b1, 1'b0, 1'b1));
    send_scan(mk_scan('0, 10'b0001000000, 10'b0101000000, 1'b1, 1'b0, 1'b0));
    send_scan(mk_scan(10'b0000000010, 10'b0100000000, 10'b0000000010, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_riff_profile();
    drain_events();
    load_config(1'b1, rand_scale(), rand_scale());
    send_scan(mk_scan('0, '0, '0, 1'b1, 1'b0, 1'b1));
    send_scan(mk_scan('0, '0, '0, 1'b1, 1'b1, 1'b0));
    send_scan(mk_scan('0, 10'b1111111111, 10'b1111111111, 1'b1, 1'b1, 1'b0));
    send_scan(mk_scan(10'b0000010000, '0, 10'b0000010000, 1'b1, 1'b1, 1'b1));
    send_scan(mk_scan('0, '0, '0, 1'b1, 1'b1, 1'b1));
    drain_events();
    load_config(1'b0, rand_scale(), rand_scale());
    send_scan(mk_scan('0, '0, '0, 1'b1, 1'b0, 1'b1));
    send_scan(mk_scan(10'b1000000000, '0, 10'b1000000000, 1'b1, 1'b0, 1'b0));
    drain_events();
    load_config(1'b1, '0, '0);
    send_scan(mk_scan(10'b1111111111, '0, 10'b1111111111, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_field_extremes();
    drain_events();
    load_config(1'b0, {SCALE_W{1'b1}}, {SCALE_W{1'b1}});
    send_scan(mk_scan('1, '1, '1, 1'b1, 1'b1, 1'b1));
    send_scan(mk_scan('0, '1, '0, 1'b0, 1'b1, 1'b0));
    send_scan(mk_scan('0, '0, '0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random_scans();
    logic               profile;
    logic [SCALE_W-1:0] lo;
    logic [SCALE_W-1:0] hi;
    for (int phase = 0; phase < PHASES; phase++) begin
      profile = 1'($urandom);
      lo      = rand_scale();
      hi      = rand_scale();
      case (phase)
        0: profile = 1'b0;
        1: profile = 1'b1;
        2: begin
          lo = '0;
          hi = '0;
        end
        3: begin
          lo = '1;
          hi = '1;
        end
        default: ;
      endcase
      drain_events();
      load_config(profile, lo, hi);
      for (int n = 0; n < PHASE_SCANS; n++) begin
        if (phase == 2 && n == PHASE_SCANS / 2) drain_events();
        send_scan(next_random_scan());
      end
    end
  endtask

  initial begin : event_sink
    int     stall;
    logic   vld;
    event_t got;
    event_t want;
    event_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      event_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        vld = event_ch.valid;
        got = event_ch.payload;
        @(posedge clk_i);
      end while (!vld);
      if (expected_events.size() == 0) begin
        report_mismatch("event with no scan behind it", int'(got.note_number), -1);
      end else begin
        want = expected_events.pop_front();
        if (got.event_kind != want.event_kind)
          report_mismatch("event_kind", int'(got.event_kind), int'(want.event_kind));
        if (got.note_number != want.note_number)
          report_mismatch("note_number", int'(got.note_number), int'(want.note_number));
        if (got.last_event != want.last_event)
          report_mismatch("last_event", int'(got.last_event), int'(want.last_event));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (scan_ch.valid && scan_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("mono_note_priority_assigner_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PROFILE;
    cfg_wdata_i     = '0;
    scan_ch.valid   = 1'b0;
    scan_ch.payload = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_scale_profile();
    test_riff_profile();
    test_field_extremes();
    test_random_scans();
    drain_events();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("mono_note_priority_assigner_top regression: pass");
    end else begin
      $display("mono_note_priority_assigner_top regression: fail");
    end
    $finish;
  end

endmodule
